// ----- hw/rtl/qhct_pkg.sv -----
// qhct_pkg: shared types and constants of the quiet history counter table
// used by the controller, the datapath and the top level
// no dependencies

package qhct_pkg;

	localparam int unsigned CounterW   = 16;
	localparam int unsigned TableDepth = 8192;
	localparam int unsigned AddrW      = $clog2(TableDepth);
	localparam int unsigned BonusW     = 15;
	localparam int unsigned DepthW     = 9;
	localparam int unsigned CfgIndexW  = 2;
	localparam int unsigned CfgDataW   = 16;

	localparam logic [CfgIndexW-1:0] CFG_BONUS_LIMIT = 2'd0;
	localparam logic [CfgIndexW-1:0] CFG_COUNTER_MAX = 2'd1;
	localparam logic [CfgIndexW-1:0] CFG_COUNTER_MIN = 2'd2;

	localparam logic [BonusW-1:0]          BONUS_LIMIT_RST = 15'd16384;
	localparam logic [BonusW-1:0]          COUNTER_MAX_RST = 15'd16384;
	localparam logic signed [CounterW-1:0] COUNTER_MIN_RST = -16'sd16384;

	// commands from the controller to the datapath
	typedef struct packed {
		logic clr_we;   // write zero at the sweep address
		logic load;     // item transfer: capture fields, start table read
		logic upd_we;   // write back the updated counter
		logic out_load; // capture the query result
	} qhct_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic clr_last; // sweep address at the final entry
		logic is_update;
		logic quiet;
	} qhct_status_t;

endpackage

// ----- hw/rtl/qhct_ram.sv -----
// qhct_ram: generic single write port, single read port ram
// registered read data; no dependencies

module qhct_ram #(
	parameter int unsigned Width = 16,
	parameter int unsigned Depth = 8192,
	localparam int unsigned AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hw/rtl/qhct_ctrl.sv -----
// qhct_ctrl: controller state machine of the quiet history counter table
// sequences the clearing sweep, item transfers and result hand-off
// depends on qhct_pkg

module qhct_ctrl
	import qhct_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	output logic         out_valid,
	input  logic         out_ready,
	input  qhct_status_t status,
	output qhct_cmd_t    cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_CALC  = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q, out_valid_d;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		out_valid_d  = out_valid_q && !out_ready;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (status.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_CALC;
				end
			end
			ST_CALC: begin
				if (status.is_update) begin
					cmd.upd_we = status.quiet;
					state_d    = ST_IDLE;
				end else if (out_free) begin
					// ram read data holds until the slot frees
					cmd.out_load = 1'b1;
					out_valid_d  = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= out_valid_d;
		end
	end

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("second item taken while one is in flight");

	a_result_from_calc: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == ST_CALC && !status.is_update))
		else $error("result raised outside a query");

	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.upd_we && (cmd.clr_we || cmd.out_load)))
		else $error("update write overlaps another command");

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !out_valid_q)
		else $error("result pending during the clearing sweep");

endmodule

// ----- hw/rtl/qhct_dp.sv -----
// qhct_dp: datapath of the quiet history counter table
// configuration registers, item registers, counter ram and saturating update
// depends on qhct_pkg and qhct_ram

module qhct_dp
	import qhct_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  qhct_cmd_t                  cmd,
	output qhct_status_t               status,
	input  logic                       cfg_we,
	input  logic [CfgIndexW-1:0]       cfg_index,
	input  logic [CfgDataW-1:0]        cfg_data,
	input  logic                       kind,
	input  logic                       side_to_move,
	input  logic [5:0]                 from_square,
	input  logic [5:0]                 to_square,
	input  logic                       has_capture,
	input  logic                       has_promotion,
	input  logic                       castling_flag,
	input  logic                       en_passant_flag,
	input  logic signed [DepthW-1:0]   search_depth,
	input  logic                       success,
	output logic signed [CounterW-1:0] score
);

	logic [BonusW-1:0]          bonus_limit_q;
	logic [BonusW-1:0]          counter_max_q;
	logic signed [CounterW-1:0] counter_min_q;

	logic             kind_q, quiet_q, success_q;
	logic [AddrW-1:0] addr_q;
	logic [BonusW-1:0] bonus_q;
	logic [AddrW-1:0] clr_addr_q;
	logic signed [CounterW-1:0] score_q;

	logic [7:0]             depth_clamped;
	logic [15:0]            depth_sq;
	logic [BonusW-1:0]      bonus_d;
	logic [AddrW-1:0]       raddr;
	logic [CounterW-1:0]    rdata;
	logic signed [17:0]     entry_ext, bonus_ext, max_ext, min_ext, sum, diff, next_val;
	logic                   ram_we;
	logic [AddrW-1:0]       ram_waddr;
	logic [CounterW-1:0]    ram_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bonus_limit_q <= BONUS_LIMIT_RST;
			counter_max_q <= COUNTER_MAX_RST;
			counter_min_q <= COUNTER_MIN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_BONUS_LIMIT: bonus_limit_q <= cfg_data[BonusW-1:0];
				CFG_COUNTER_MAX: counter_max_q <= cfg_data[BonusW-1:0];
				CFG_COUNTER_MIN: counter_min_q <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// depth below 1 counts as 1, so the clamped depth fits 8 bits
	assign depth_clamped = (search_depth < 9'sd1) ? 8'd1 : search_depth[7:0];
	assign depth_sq      = depth_clamped * depth_clamped;
	assign bonus_d       = (depth_sq < {1'b0, bonus_limit_q}) ? depth_sq[BonusW-1:0]
	                                                          : bonus_limit_q;

	assign raddr = {side_to_move, from_square, to_square};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q    <= kind;
			quiet_q   <= !(has_capture || has_promotion || castling_flag || en_passant_flag);
			success_q <= success;
			addr_q    <= raddr;
			bonus_q   <= bonus_d;
		end
		if (cmd.out_load) begin
			score_q <= quiet_q ? $signed(rdata) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clr_we) begin
			clr_addr_q <= clr_addr_q + 1'b1;
		end
	end

	// saturating update, 18 bits keeps every sum in range
	assign entry_ext = $signed({{2{rdata[CounterW-1]}}, rdata});
	assign bonus_ext = $signed({3'b000, bonus_q});
	assign max_ext   = $signed({3'b000, counter_max_q});
	assign min_ext   = $signed({{2{counter_min_q[CounterW-1]}}, counter_min_q});
	assign sum       = entry_ext + bonus_ext;
	assign diff      = entry_ext - bonus_ext;

	always_comb begin
		if (success_q) begin
			next_val = (sum > max_ext) ? max_ext : sum;
		end else begin
			next_val = (diff < min_ext) ? min_ext : diff;
		end
	end

	assign ram_we    = cmd.clr_we || cmd.upd_we;
	assign ram_waddr = cmd.clr_we ? clr_addr_q : addr_q;
	assign ram_wdata = cmd.clr_we ? '0 : next_val[CounterW-1:0];

	qhct_ram #(
		.Width(CounterW),
		.Depth(TableDepth)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.load),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign status.clr_last  = &clr_addr_q;
	assign status.is_update = kind_q;
	assign status.quiet     = quiet_q;
	assign score            = score_q;

endmodule

// ----- hw/rtl/quiet_history_counter_table_core.sv -----
// Quiet history counter table: 8192 signed 16-bit counters indexed by side to
// move, origin square and destination square.
//
// Channels: the item channel (in_valid/in_ready) carries a query (kind 0) or
// an update (kind 1). A query gives one result on out_valid/out_ready holding
// the counter of a quiet move, or 0 for a move with a capture, promotion,
// castling or en passant. An update adds min(depth squared, bonus_limit) on
// success up to counter_max, or subtracts it on failure down to counter_min.
// The cfg channel writes bonus_limit (0), counter_max (1), counter_min (2);
// other indexes are dropped. cfg_ready is always high.
//
// Throughput: a new item is taken only after the last one is done, set by the
// registered read of the single counter ram followed by its write-back or its
// result capture. A query result is loaded into the output register in CALC.
// Reset: configuration returns to its defaults and the table is swept to zero
// one entry per cycle, 8192 entries, with in_ready low; cfg writes are taken.
// Stall: the result sits in an output register; the next item is still taken,
// and a following query waits with in_ready low until the register frees.
// depends on qhct_pkg, qhct_ctrl, qhct_dp

module quiet_history_counter_table_core
	import qhct_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CfgIndexW-1:0]       cfg_index,
	input  logic [CfgDataW-1:0]        cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       kind,
	input  logic                       side_to_move,
	input  logic [5:0]                 from_square,
	input  logic [5:0]                 to_square,
	input  logic                       has_capture,
	input  logic                       has_promotion,
	input  logic                       castling_flag,
	input  logic                       en_passant_flag,
	input  logic signed [DepthW-1:0]   search_depth,
	input  logic                       success,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [CounterW-1:0] score
);

	qhct_cmd_t    cmd;
	qhct_status_t status;

	assign cfg_ready = 1'b1;

	qhct_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status   (status),
		.cmd      (cmd)
	);

	qhct_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.kind           (kind),
		.side_to_move   (side_to_move),
		.from_square    (from_square),
		.to_square      (to_square),
		.has_capture    (has_capture),
		.has_promotion  (has_promotion),
		.castling_flag  (castling_flag),
		.en_passant_flag(en_passant_flag),
		.search_depth   (search_depth),
		.success        (success),
		.score          (score)
	);

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
// tb: self-checking bench for quiet_history_counter_table_core
// directed moves, then random moves under several limit settings, scores checked in order
// depends on qhct_pkg and the core rtl

module tb;
	import qhct_pkg::*;

	localparam logic KIND_QUERY  = 1'b0;
	localparam logic KIND_UPDATE = 1'b1;
	localparam logic [CfgIndexW-1:0] CFG_SPARE = 2'd3;
	localparam int PHASE_COUNT = 7;
	localparam int PHASE_ITEMS = 180;
	localparam int HOT_COUNT   = 6;

	typedef struct {
		logic                     kind;
		logic                     color;
		logic [5:0]               from_sq;
		logic [5:0]               to_sq;
		logic                     cap;
		logic                     promo;
		logic                     castle;
		logic                     ep;
		logic signed [DepthW-1:0] depth;
		logic                     good;
	} move_t;

	typedef struct {
		move_t                      mv;
		bit                         typed;
		logic signed [CounterW-1:0] score;
	} dir_row_t;

	logic                       clk;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic [CfgIndexW-1:0]       cfg_index = '0;
	logic [CfgDataW-1:0]        cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_ready;
	logic                       kind = 1'b0;
	logic                       side_to_move = 1'b0;
	logic [5:0]                 from_square = '0;
	logic [5:0]                 to_square = '0;
	logic                       has_capture = 1'b0;
	logic                       has_promotion = 1'b0;
	logic                       castling_flag = 1'b0;
	logic                       en_passant_flag = 1'b0;
	logic signed [DepthW-1:0]   search_depth = '0;
	logic                       success = 1'b0;
	logic                       out_valid;
	logic                       out_ready = 1'b0;
	logic signed [CounterW-1:0] score;

	// shadow of the counter table and the limit registers
	logic signed [CounterW-1:0] shadow_table [TableDepth];
	int lim_bonus;
	int lim_max;
	int lim_min;

	logic signed [CounterW-1:0] pending_scores [$];
	dir_row_t directed_rows [$];
	logic [AddrW-1:0] hot_moves [HOT_COUNT];
	int success_pct = 50;
	int mismatches = 0;
	int send_calm = 0;
	int recv_calm = 0;

	quiet_history_counter_table_core u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.side_to_move   (side_to_move),
		.from_square    (from_square),
		.to_square      (to_square),
		.has_capture    (has_capture),
		.has_promotion  (has_promotion),
		.castling_flag  (castling_flag),
		.en_passant_flag(en_passant_flag),
		.search_depth   (search_depth),
		.success        (success),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.score          (score)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		for (int a = 0; a < TableDepth; a++) shadow_table[a] = '0;
		lim_bonus = int'(BONUS_LIMIT_RST);
		lim_max   = int'(COUNTER_MAX_RST);
		lim_min   = int'(COUNTER_MIN_RST);
	end

	task automatic report(input string what, input logic signed [CounterW-1:0] got,
		input logic signed [CounterW-1:0] want);
		mismatches++;
		$display("mismatch %0s: got %0d want %0d at %0t", what, got, want, $time);
	endtask

	// one move through the shadow table; a query gives a score, an update none
	task automatic history_predict(input move_t m, output bit gives,
		output logic signed [CounterW-1:0] val);
		logic [AddrW-1:0] idx;
		int entry;
		int bonus;
		int d;
		int nxt;
		bit quiet;
		idx   = {m.color, m.from_sq, m.to_sq};
		quiet = !(m.cap || m.promo || m.castle || m.ep);
		gives = 1'b0;
		val   = '0;
		if (m.kind == KIND_QUERY) begin
			gives = 1'b1;
			if (quiet) val = shadow_table[idx];
		end else if (quiet) begin
			entry = int'(shadow_table[idx]);
			d = int'(m.depth);
			if (d < 1) d = 1;
			bonus = d * d;
			if (bonus > lim_bonus) bonus = lim_bonus;
			if (m.good) begin
				nxt = entry + bonus;
				if (nxt > lim_max) nxt = lim_max;
			end else begin
				nxt = entry - bonus;
				if (nxt < lim_min) nxt = lim_min;
			end
			shadow_table[idx] = nxt[CounterW-1:0];
		end
	endtask

	function automatic move_t random_move();
		move_t m;
		logic [AddrW-1:0] a;
		m.kind = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 4) != 0) a = hot_moves[$urandom_range(0, HOT_COUNT - 1)];
		else a = AddrW'($urandom);
		{m.color, m.from_sq, m.to_sq} = a;
		if ($urandom_range(0, 4) == 0)
			{m.cap, m.promo, m.castle, m.ep} = 4'($urandom_range(1, 15));
		else
			{m.cap, m.promo, m.castle, m.ep} = 4'b0000;
		case ($urandom_range(0, 2))
			0: m.depth = DepthW'($urandom_range(0, 383) - 128);
			1: m.depth = DepthW'($urandom_range(0, 12));
			default: m.depth = DepthW'($urandom_range(120, 255));
		endcase
		m.good = $urandom_range(0, 99) < success_pct;
		return m;
	endfunction

	task automatic add_row(input logic k, input int c, input int f,
		input int t, input logic [3:0] flags, input int d, input int g,
		input int typed, input int s);
		dir_row_t r;
		r.mv.kind    = k;
		r.mv.color   = c[0];
		r.mv.from_sq = f[5:0];
		r.mv.to_sq   = t[5:0];
		{r.mv.cap, r.mv.promo, r.mv.castle, r.mv.ep} = flags;
		r.mv.depth   = d[DepthW-1:0];
		r.mv.good    = g[0];
		r.typed      = (typed != 0);
		r.score      = s[CounterW-1:0];
		directed_rows.push_back(r);
	endtask

	// leaves in_valid high after the transfer for the next call, or for the caller to lower
	task automatic send_move(input move_t m, input bit typed,
		input logic signed [CounterW-1:0] typed_score);
		int gap;
		bit gives;
		logic signed [CounterW-1:0] val;
		if (send_calm > 0) begin
			gap = 0;
			send_calm--;
		end else begin
			if ($urandom_range(0, 7) == 0) send_calm = $urandom_range(10, 40);
			gap = $urandom_range(0, 11);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		kind            <= m.kind;
		side_to_move    <= m.color;
		from_square     <= m.from_sq;
		to_square       <= m.to_sq;
		has_capture     <= m.cap;
		has_promotion   <= m.promo;
		castling_flag   <= m.castle;
		en_passant_flag <= m.ep;
		search_depth    <= m.depth;
		success         <= m.good;
		in_valid        <= 1'b1;
		do @(posedge clk); while (!in_ready);
		history_predict(m, gives, val);
		if (gives) pending_scores.push_back(typed ? typed_score : val);
	endtask

	task automatic cfg_write(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_BONUS_LIMIT: lim_bonus = int'(data[BonusW-1:0]);
			CFG_COUNTER_MAX: lim_max = int'(data[BonusW-1:0]);
			CFG_COUNTER_MIN: lim_min = int'($signed(data));
			default: ;
		endcase
	endtask

	// top bit of the cfg data for the 15-bit registers is junk and must be dropped
	task automatic set_limits(input logic [BonusW-1:0] bl, input logic [BonusW-1:0] cm,
		input logic signed [CounterW-1:0] cmn);
		logic top;
		top = 1'($urandom_range(0, 1));
		cfg_write(CFG_BONUS_LIMIT, {top, bl});
		cfg_write(CFG_SPARE, CfgDataW'($urandom));
		top = 1'($urandom_range(0, 1));
		cfg_write(CFG_COUNTER_MAX, {top, cm});
		cfg_write(CFG_COUNTER_MIN, cmn);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drain();
		int n;
		n = 0;
		while (pending_scores.size() != 0 && n < 4000) begin
			@(posedge clk);
			n++;
		end
		if (pending_scores.size() != 0) begin
			report("scores never returned", CounterW'(pending_scores.size()), '0);
			pending_scores.delete();
		end
		repeat (8) @(posedge clk);
	endtask

	initial begin : score_sink
		int stall;
		logic signed [CounterW-1:0] want;
		@(posedge arst_n);
		forever begin
			if (recv_calm > 0) begin
				stall = 0;
				recv_calm--;
			end else begin
				if ($urandom_range(0, 7) == 0) recv_calm = $urandom_range(5, 20);
				stall = $urandom_range(0, 11);
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_scores.size() == 0) begin
				report("score with no query waiting", score, '0);
			end else begin
				want = pending_scores.pop_front();
				if (score !== want) report("score", score, want);
			end
		end
	end

	initial begin : stimulus
		move_t m;
		dir_row_t r;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// default limits: bonus 16384, max 16384, min -16384
		add_row(KIND_QUERY, 0, 0, 0, 4'b0000, 0, 0, 1, 0);
		add_row(KIND_QUERY, 1, 63, 63, 4'b0000, 0, 1, 1, 0);
		add_row(KIND_UPDATE, 0, 0, 0, 4'b0000, 255, 1, 0, 0);
		add_row(KIND_QUERY, 0, 0, 0, 4'b0000, 0, 0, 1, 16384);
		add_row(KIND_UPDATE, 0, 0, 0, 4'b0000, 3, 1, 0, 0);
		add_row(KIND_QUERY, 0, 0, 0, 4'b0000, -128, 1, 1, 16384);
		// any non-quiet flag hides the counter
		add_row(KIND_QUERY, 0, 0, 0, 4'b1000, 0, 0, 1, 0);
		add_row(KIND_QUERY, 0, 0, 0, 4'b0100, 0, 0, 1, 0);
		add_row(KIND_QUERY, 0, 0, 0, 4'b0010, 0, 0, 1, 0);
		add_row(KIND_QUERY, 0, 0, 0, 4'b0001, 0, 0, 1, 0);
		add_row(KIND_UPDATE, 0, 0, 0, 4'b1000, 255, 0, 0, 0);
		add_row(KIND_UPDATE, 0, 0, 0, 4'b0001, 255, 0, 0, 0);
		add_row(KIND_QUERY, 0, 0, 0, 4'b0000, 0, 0, 1, 16384);
		// shallow depths count as one
		add_row(KIND_UPDATE, 1, 63, 63, 4'b0000, -128, 0, 0, 0);
		add_row(KIND_QUERY, 1, 63, 63, 4'b0000, 0, 0, 1, -1);
		add_row(KIND_UPDATE, 1, 63, 63, 4'b0000, 0, 0, 0, 0);
		add_row(KIND_UPDATE, 1, 63, 63, 4'b0000, 1, 0, 0, 0);
		add_row(KIND_QUERY, 1, 63, 63, 4'b0000, 0, 0, 1, -3);
		add_row(KIND_UPDATE, 1, 63, 63, 4'b0000, 255, 0, 0, 0);
		add_row(KIND_QUERY, 1, 63, 63, 4'b0000, 0, 0, 1, -16384);
		add_row(KIND_UPDATE, 1, 63, 63, 4'b0000, 128, 0, 0, 0);
		add_row(KIND_QUERY, 1, 63, 63, 4'b0000, 0, 1, 1, -16384);
		add_row(KIND_UPDATE, 0, 1, 2, 4'b0000, 7, 1, 0, 0);
		add_row(KIND_QUERY, 0, 1, 2, 4'b0000, 7, 1, 0, 0);
		add_row(KIND_UPDATE, 1, 5, 40, 4'b0110, 255, 1, 0, 0);
		add_row(KIND_QUERY, 1, 5, 40, 4'b0000, 0, 0, 1, 0);

		foreach (directed_rows[i]) begin
			r = directed_rows[i];
			send_move(r.mv, r.typed, r.score);
		end
		in_valid <= 1'b0;
		wait_drain();

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: set_limits(15'd0, 15'd32767, -16'sd32768);
				1: set_limits(15'd32767, 15'd32767, -16'sd32768);
				2: set_limits(15'd32767, 15'd0, 16'sd0);
				3: set_limits(15'd50, 15'd200, -16'sd200);
				4: set_limits(15'd1000, 15'd500, 16'sd300);
				5: set_limits(BonusW'($urandom_range(0, 32767)),
					BonusW'($urandom_range(0, 32767)),
					CounterW'(-$urandom_range(0, 32768)));
				default: set_limits(BONUS_LIMIT_RST, COUNTER_MAX_RST, COUNTER_MIN_RST);
			endcase
			// a few hot entries so updates pile up and reach the bounds
			hot_moves[0] = $urandom_range(0, 1) ? '0 : '1;
			for (int h = 1; h < HOT_COUNT; h++) hot_moves[h] = AddrW'($urandom);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				if (i % 40 == 0) begin
					case ($urandom_range(0, 2))
						0: success_pct = 15;
						1: success_pct = 50;
						default: success_pct = 85;
					endcase
				end
				m = random_move();
				send_move(m, 1'b0, '0);
			end
			in_valid <= 1'b0;
			wait_drain();
		end

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
